>>> hdl/drm_pkg.sv
// ----------------------------------------------------------------------------
// drm_pkg
// Shared codes and fixed field widths for the damage rectangle merger:
// item modes, result outcomes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package drm_pkg;

	// fixed field widths
	localparam int REG_W      = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int IN_W       = 16;
	localparam int IDX_IN_W   = 6;
	localparam int CNT_OUT_W  = 5;

	typedef logic [1:0] mode_t;
	typedef logic [2:0] outcome_t;

	// item modes
	localparam mode_t MODE_ADD   = 2'd0;
	localparam mode_t MODE_CLEAR = 2'd1;
	localparam mode_t MODE_READ  = 2'd2;
	localparam mode_t MODE_RSVD  = 2'd3;

	// result outcomes
	localparam outcome_t OUT_REJECTED  = 3'd0;
	localparam outcome_t OUT_MERGED    = 3'd1;
	localparam outcome_t OUT_APPENDED  = 3'd2;
	localparam outcome_t OUT_COLLAPSED = 3'd3;
	localparam outcome_t OUT_CLEARED   = 3'd4;
	localparam outcome_t OUT_READ_OK   = 3'd5;
	localparam outcome_t OUT_READ_BAD  = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 1'b1;

	// register reset values
	localparam logic [REG_W-1:0] SCREEN_W_RST = 14'd1024;
	localparam logic [REG_W-1:0] SCREEN_H_RST = 14'd768;

endpackage

>>> hdl/damage_rect_merger_core.sv
// ----------------------------------------------------------------------------
// damage_rect_merger_core
// Damage rectangle table: clip, scan for the first overlap, merge, append
// or collapse to full screen; clear and read items.
// ----------------------------------------------------------------------------
// sequence: an add is clipped, then scans the stored entries (if any) for the first
// overlap; it merges at that entry, or else appends or collapses in the write state;
// a bad or clipped-out add is rejected; clear, read and unknown modes go straight to done
// throughput: one item at a time, next accept in the cycle after the result beat
// is loaded; the scan reads one entry per cycle via the shared unit
// reset: count cleared, screen size 1024 x 768, table contents undefined
// ----------------------------------------------------------------------------
module damage_rect_merger_core #(
	parameter int MAX_RECTS  = 16,
	parameter int COORD_BITS = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [drm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [drm_pkg::REG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       mode,
	input  logic signed [drm_pkg::IN_W-1:0]  rect_x,
	input  logic signed [drm_pkg::IN_W-1:0]  rect_y,
	input  logic signed [drm_pkg::IN_W-1:0]  rect_width,
	input  logic signed [drm_pkg::IN_W-1:0]  rect_height,
	input  logic [drm_pkg::IDX_IN_W-1:0]     read_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       outcome,
	output logic [drm_pkg::REG_W-1:0]        entry_x,
	output logic [drm_pkg::REG_W-1:0]        entry_y,
	output logic [drm_pkg::REG_W-1:0]        entry_width,
	output logic [drm_pkg::REG_W-1:0]        entry_height,
	output logic [drm_pkg::CNT_OUT_W-1:0]    entry_count,
	output logic                             has_damage
);

	localparam int IDX_W  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNT_W  = $clog2(MAX_RECTS + 1);
	localparam int CW     = ((COORD_BITS > drm_pkg::REG_W) ? COORD_BITS : drm_pkg::REG_W) + 1;
	localparam int ENT_W  = 4 * COORD_BITS;
	localparam int CNTX_W = (CNT_W > drm_pkg::CNT_OUT_W) ? CNT_W : drm_pkg::CNT_OUT_W;
	localparam int CMP_W  = (CNT_W > drm_pkg::IDX_IN_W) ? CNT_W : drm_pkg::IDX_IN_W;
	localparam int EXW    = (COORD_BITS > drm_pkg::REG_W) ? COORD_BITS : drm_pkg::REG_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CLIP  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                    state_q;
	logic [drm_pkg::REG_W-1:0] sw_q;
	logic [drm_pkg::REG_W-1:0] sh_q;
	logic [CNT_W-1:0]          count_q;
	logic [IDX_W-1:0]          scan_q;
	logic [IDX_W-1:0]          rd_idx_q;
	logic                      rd_ok_q;
	drm_pkg::outcome_t         res_q;
	logic signed [drm_pkg::IN_W-1:0] rx_q;
	logic signed [drm_pkg::IN_W-1:0] ry_q;
	logic signed [drm_pkg::IN_W-1:0] rw_q;
	logic signed [drm_pkg::IN_W-1:0] rh_q;
	logic [CW-1:0]             ax1_q;
	logic [CW-1:0]             ay1_q;
	logic [CW-1:0]             ax2_q;
	logic [CW-1:0]             ay2_q;

	logic                      accept;
	logic                      out_free;
	logic                      full;
	logic [CNT_W-1:0]          scan_next;
	logic                      scan_last;

	// clip datapath
	logic signed [drm_pkg::IN_W:0] x_ext;
	logic signed [drm_pkg::IN_W:0] y_ext;
	logic signed [drm_pkg::IN_W:0] x2_raw;
	logic signed [drm_pkg::IN_W:0] y2_raw;
	logic signed [drm_pkg::IN_W:0] sw_s;
	logic signed [drm_pkg::IN_W:0] sh_s;
	logic signed [drm_pkg::IN_W:0] x1c;
	logic signed [drm_pkg::IN_W:0] y1c;
	logic signed [drm_pkg::IN_W:0] x2c;
	logic signed [drm_pkg::IN_W:0] y2c;
	logic                      size_bad;
	logic                      clip_empty;

	// shared unit operands and results
	logic [CW-1:0]             u_ax1, u_ay1, u_ax2, u_ay2;
	logic [CW-1:0]             u_bx1, u_by1, u_bx2, u_by2;
	logic                      u_overlap;
	logic [COORD_BITS-1:0]     u_st_x, u_st_y, u_st_w, u_st_h;

	// table ports
	logic                      tb_wr_en;
	logic [IDX_W-1:0]          tb_wr_addr;
	logic [ENT_W-1:0]          tb_wr_data;
	logic [IDX_W-1:0]          tb_rd_addr;
	logic [ENT_W-1:0]          tb_rd_data;
	logic [COORD_BITS-1:0]     e_x, e_y, e_w, e_h;
	logic [EXW-1:0]            ex_x, ex_y, ex_w, ex_h;
	logic [CNTX_W-1:0]         cnt_ext;
	logic                      rd_in_range;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;
	assign full      = (count_q == CNT_W'(MAX_RECTS));
	assign scan_next = CNT_W'(scan_q) + CNT_W'(1);
	assign scan_last = (scan_next == count_q);

	assign rd_in_range = (CMP_W'(read_index) < CMP_W'(count_q));

	// clip the captured rectangle to the screen
	assign x_ext      = {rx_q[drm_pkg::IN_W-1], rx_q};
	assign y_ext      = {ry_q[drm_pkg::IN_W-1], ry_q};
	assign x2_raw     = x_ext + {rw_q[drm_pkg::IN_W-1], rw_q};
	assign y2_raw     = y_ext + {rh_q[drm_pkg::IN_W-1], rh_q};
	assign sw_s       = {3'b000, sw_q};
	assign sh_s       = {3'b000, sh_q};
	assign x1c        = rx_q[drm_pkg::IN_W-1] ? '0 : x_ext;
	assign y1c        = ry_q[drm_pkg::IN_W-1] ? '0 : y_ext;
	assign x2c        = (x2_raw > sw_s) ? sw_s : x2_raw;
	assign y2c        = (y2_raw > sh_s) ? sh_s : y2_raw;
	assign size_bad   = (rw_q <= 0) || (rh_q <= 0);
	assign clip_empty = (x1c >= x2c) || (y1c >= y2c);

	// unpack the entry read from the table
	assign e_x = tb_rd_data[4*COORD_BITS-1:3*COORD_BITS];
	assign e_y = tb_rd_data[3*COORD_BITS-1:2*COORD_BITS];
	assign e_w = tb_rd_data[2*COORD_BITS-1:COORD_BITS];
	assign e_h = tb_rd_data[COORD_BITS-1:0];

	// shared unit operand select
	always_comb begin
		u_ax1 = ax1_q;
		u_ay1 = ay1_q;
		u_ax2 = ax2_q;
		u_ay2 = ay2_q;
		u_bx1 = ax1_q;
		u_by1 = ay1_q;
		u_bx2 = ax2_q;
		u_by2 = ay2_q;
		case (state_q)
			ST_SCAN: begin
				u_bx1 = CW'(e_x);
				u_by1 = CW'(e_y);
				u_bx2 = CW'(e_x) + CW'(e_w);
				u_by2 = CW'(e_y) + CW'(e_h);
			end
			ST_WRITE: begin
				if (full) begin
					u_ax1 = '0;
					u_ay1 = '0;
					u_ax2 = CW'(sw_q);
					u_ay2 = CW'(sh_q);
					u_bx1 = '0;
					u_by1 = '0;
					u_bx2 = CW'(sw_q);
					u_by2 = CW'(sh_q);
				end
			end
			default: begin
			end
		endcase
	end

	drm_ovl #(
		.CW (CW),
		.CB (COORD_BITS)
	) u_ovl (
		.a_x1    (u_ax1),
		.a_y1    (u_ay1),
		.a_x2    (u_ax2),
		.a_y2    (u_ay2),
		.b_x1    (u_bx1),
		.b_y1    (u_by1),
		.b_x2    (u_bx2),
		.b_y2    (u_by2),
		.overlap (u_overlap),
		.st_x    (u_st_x),
		.st_y    (u_st_y),
		.st_w    (u_st_w),
		.st_h    (u_st_h)
	);

	// table write and read addressing
	assign tb_wr_en   = ((state_q == ST_SCAN) && u_overlap) || (state_q == ST_WRITE);
	assign tb_wr_data = {u_st_x, u_st_y, u_st_w, u_st_h};

	always_comb begin
		if (state_q == ST_SCAN) begin
			tb_wr_addr = scan_q;
		end else if (full) begin
			tb_wr_addr = '0;
		end else begin
			tb_wr_addr = count_q[IDX_W-1:0];
		end
	end

	always_comb begin
		case (state_q)
			ST_IDLE: tb_rd_addr = read_index[IDX_W-1:0];
			ST_CLIP: tb_rd_addr = '0;
			ST_SCAN: tb_rd_addr = scan_next[IDX_W-1:0];
			default: tb_rd_addr = rd_idx_q;
		endcase
	end

	drm_table #(
		.DEPTH  (MAX_RECTS),
		.IDX_W  (IDX_W),
		.DATA_W (ENT_W)
	) u_table (
		.clk     (clk),
		.wr_en   (tb_wr_en),
		.wr_addr (tb_wr_addr),
		.wr_data (tb_wr_data),
		.rd_addr (tb_rd_addr),
		.rd_data (tb_rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= drm_pkg::SCREEN_W_RST;
			sh_q <= drm_pkg::SCREEN_H_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				drm_pkg::CFG_SCREEN_W: sw_q <= cfg_data;
				drm_pkg::CFG_SCREEN_H: sh_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_q     <= rect_x;
			ry_q     <= rect_y;
			rw_q     <= rect_width;
			rh_q     <= rect_height;
			rd_idx_q <= read_index[IDX_W-1:0];
		end
		if (state_q == ST_CLIP) begin
			ax1_q <= CW'(x1c[drm_pkg::REG_W-1:0]);
			ay1_q <= CW'(y1c[drm_pkg::REG_W-1:0]);
			ax2_q <= CW'(x2c[drm_pkg::REG_W-1:0]);
			ay2_q <= CW'(y2c[drm_pkg::REG_W-1:0]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			res_q   <= drm_pkg::OUT_REJECTED;
			rd_ok_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_ok_q <= (mode == drm_pkg::MODE_READ) && rd_in_range;
						case (mode)
							drm_pkg::MODE_ADD: begin
								state_q <= ST_CLIP;
							end
							drm_pkg::MODE_CLEAR: begin
								count_q <= '0;
								res_q   <= drm_pkg::OUT_CLEARED;
								state_q <= ST_DONE;
							end
							drm_pkg::MODE_READ: begin
								res_q   <= rd_in_range ? drm_pkg::OUT_READ_OK
								                       : drm_pkg::OUT_READ_BAD;
								state_q <= ST_DONE;
							end
							default: begin
								res_q   <= drm_pkg::OUT_REJECTED;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CLIP: begin
					scan_q <= '0;
					if (size_bad || clip_empty) begin
						res_q   <= drm_pkg::OUT_REJECTED;
						state_q <= ST_DONE;
					end else if (count_q == '0) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (u_overlap) begin
						res_q   <= drm_pkg::OUT_MERGED;
						state_q <= ST_DONE;
					end else if (scan_last) begin
						state_q <= ST_WRITE;
					end else begin
						scan_q <= scan_next[IDX_W-1:0];
					end
				end
				ST_WRITE: begin
					if (full) begin
						count_q <= CNT_W'(1);
						res_q   <= drm_pkg::OUT_COLLAPSED;
					end else begin
						count_q <= count_q + CNT_W'(1);
						res_q   <= drm_pkg::OUT_APPENDED;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result fields
	assign ex_x    = EXW'(e_x);
	assign ex_y    = EXW'(e_y);
	assign ex_w    = EXW'(e_w);
	assign ex_h    = EXW'(e_h);
	assign cnt_ext = CNTX_W'(count_q);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			outcome     <= res_q;
			entry_count <= cnt_ext[drm_pkg::CNT_OUT_W-1:0];
			has_damage  <= (count_q != '0);
			if (rd_ok_q) begin
				entry_x      <= ex_x[drm_pkg::REG_W-1:0];
				entry_y      <= ex_y[drm_pkg::REG_W-1:0];
				entry_width  <= ex_w[drm_pkg::REG_W-1:0];
				entry_height <= ex_h[drm_pkg::REG_W-1:0];
			end else begin
				entry_x      <= '0;
				entry_y      <= '0;
				entry_width  <= '0;
				entry_height <= '0;
			end
		end
	end

endmodule

>>> hdl/drm_table.sv
// ----------------------------------------------------------------------------
// drm_table
// Rectangle table storage: one write port, one read port with registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module drm_table #(
	parameter int DEPTH  = 16,
	parameter int IDX_W  = 4,
	parameter int DATA_W = 56
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> hdl/drm_ovl.sv
// ----------------------------------------------------------------------------
// drm_ovl
// Shared rectangle unit: strict overlap test of two corner-form rectangles
// and the stored form (left, top, width, height) of their bounding box.
// ----------------------------------------------------------------------------
module drm_ovl #(
	parameter int CW = 15,
	parameter int CB = 14
) (
	input  logic [CW-1:0] a_x1,
	input  logic [CW-1:0] a_y1,
	input  logic [CW-1:0] a_x2,
	input  logic [CW-1:0] a_y2,
	input  logic [CW-1:0] b_x1,
	input  logic [CW-1:0] b_y1,
	input  logic [CW-1:0] b_x2,
	input  logic [CW-1:0] b_y2,
	output logic          overlap,
	output logic [CB-1:0] st_x,
	output logic [CB-1:0] st_y,
	output logic [CB-1:0] st_w,
	output logic [CB-1:0] st_h
);

	logic [CW-1:0] mx1;
	logic [CW-1:0] my1;
	logic [CW-1:0] mx2;
	logic [CW-1:0] my2;
	logic [CW-1:0] dx;
	logic [CW-1:0] dy;

	// strict overlap on both axes
	assign overlap = (a_x1 < b_x2) && (a_x2 > b_x1) && (a_y1 < b_y2) && (a_y2 > b_y1);

	// bounding box
	assign mx1 = (a_x1 < b_x1) ? a_x1 : b_x1;
	assign my1 = (a_y1 < b_y1) ? a_y1 : b_y1;
	assign mx2 = (a_x2 > b_x2) ? a_x2 : b_x2;
	assign my2 = (a_y2 > b_y2) ? a_y2 : b_y2;

	// stored form, kept modulo the coordinate width
	assign dx   = mx2 - mx1;
	assign dy   = my2 - my1;
	assign st_x = mx1[CB-1:0];
	assign st_y = my1[CB-1:0];
	assign st_w = dx[CB-1:0];
	assign st_h = dy[CB-1:0];

endmodule

>>> hdl/drm_checker.sv
// ----------------------------------------------------------------------------
// drm_checker
// Port-level checks for the damage rectangle merger, bound to the top level.
// ----------------------------------------------------------------------------
module drm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [2:0]                    outcome,
	input logic [drm_pkg::REG_W-1:0]     entry_x,
	input logic [drm_pkg::REG_W-1:0]     entry_y,
	input logic [drm_pkg::REG_W-1:0]     entry_width,
	input logic [drm_pkg::REG_W-1:0]     entry_height,
	input logic [drm_pkg::CNT_OUT_W-1:0] entry_count,
	input logic                          has_damage
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(entry_count))
		else $error("result beat changed while stalled");

	// one item at a time: not ready right after an accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accept");

	// a clear leaves an empty table
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == drm_pkg::OUT_CLEARED) |-> (entry_count == '0) && !has_damage)
		else $error("clear reported stored entries");

	// entry fields only carry data on a good read
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome != drm_pkg::OUT_READ_OK) |->
		(entry_x == '0) && (entry_y == '0) && (entry_width == '0) && (entry_height == '0))
		else $error("entry fields nonzero outside a good read");

	// a stored rectangle means damage
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((outcome == drm_pkg::OUT_MERGED) || (outcome == drm_pkg::OUT_APPENDED) ||
		(outcome == drm_pkg::OUT_COLLAPSED)) |-> has_damage)
		else $error("no damage flagged after a store");

endmodule

bind damage_rect_merger_core drm_checker u_drm_checker (.*);
